>>> rtl/core/wbmpv_pkg.sv
package wbmpv_pkg;

  // Field widths of the header and of the result.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 32;
  localparam int unsigned HLEN_W   = 5;
  localparam int unsigned FCNT_W   = 3;
  localparam int unsigned EXP_W    = 61;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FSIZE_W  = 64;
  localparam int unsigned ROW_W    = DIM_W - 2;

  // A multi-byte integer ends after this many bytes even if bit 7 is still set.
  localparam logic [FCNT_W-1:0] MBI_MAX_BYTES = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_VALID     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FIXED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SIZE_MISM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;

  // Configuration register byte addresses.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_FILE_SIZE = 1'b0;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_TYPE   = 5'b00001,
    PH_FIXED  = 5'b00010,
    PH_WIDTH  = 5'b00100,
    PH_HEIGHT = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  // Summary of one parsed header, handed from the parser to the size check.
  typedef struct packed {
    logic              trunc;
    logic              type_nz;
    logic              fixed_nz;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [HLEN_W-1:0] hlen;
  } hdr_t;

endpackage

>>> rtl/core/wbmp_header_validator.sv
// Checks the header of a type-0 wireless bitmap streamed in one byte per transfer. The block
// takes one byte in every cycle with no gaps of its own; only a stalled result channel holds
// the input back once the three-deep result pipeline is full. A result for the byte that
// completes the height (or for the end-of-data transfer) passes from the parse into the header
// register, then through the row-bytes times height multiplier register, then through the
// header-length add and the file-size compare into the output register. Set first_byte on
// the first byte of each file; after a result, bytes are ignored until the next first byte.
// Write file_size_bytes only while no file is in flight.
module wbmp_header_validator (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // [0] first_byte
  input  logic                                in_tlast,   // end_of_data
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] image_width, [63:32] image_height, [68:64] header_length,
  // [129:69] expected_size, [135:130] zero
  output logic [135:0]                        out_tdata,
  output logic [2:0]                          out_tuser,  // [2:0] status
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wbmpv_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [63:0]                         cfg_pwdata,
  output logic [63:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic                                  in_fire;
  logic                                  emit;
  wbmpv_pkg::hdr_t                       hdr;
  logic [wbmpv_pkg::FSIZE_W-1:0]         fsize_r;

  logic                                  s1_v_r, s2_v_r, out_valid_r;
  wbmpv_pkg::hdr_t                       s1_r, s2_r;
  logic [wbmpv_pkg::EXP_W-1:0]           s2_prod_r;
  logic                                  out_adv, s2_rdy, s1_rdy;

  logic [wbmpv_pkg::DIM_W:0]             row_sum;
  logic [wbmpv_pkg::ROW_W-1:0]           row_bytes;
  logic [wbmpv_pkg::ROW_W+wbmpv_pkg::DIM_W-1:0] prod_full;
  logic [wbmpv_pkg::EXP_W-1:0]           exp_sum, exp_nxt;
  logic [wbmpv_pkg::STATUS_W-1:0]        status_nxt;

  logic [wbmpv_pkg::STATUS_W-1:0]        out_status_r;
  logic [wbmpv_pkg::DIM_W-1:0]           out_width_r, out_height_r;
  logic [wbmpv_pkg::HLEN_W-1:0]          out_hlen_r;
  logic [wbmpv_pkg::EXP_W-1:0]           out_exp_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == wbmpv_pkg::REG_FILE_SIZE) ? fsize_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == wbmpv_pkg::REG_FILE_SIZE)) begin
      fsize_r <= cfg_pwdata;
    end
  end

  // Each stage moves when the one after it is empty or moving.
  assign out_adv   = !out_valid_r || out_tready;
  assign s2_rdy    = !s2_v_r || out_adv;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_fire   = in_tvalid && in_tready;

  wbmpv_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .data_byte   (in_tdata),
    .first_byte  (in_tuser),
    .end_of_data (in_tlast),
    .emit        (emit),
    .hdr         (hdr)
  );

  // Stage 1: parsed header.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_r <= hdr;
    end
  end

  // Stage 2: packed row bytes times height.
  assign row_sum   = {1'b0, s1_r.width} + 33'd7;
  assign row_bytes = row_sum[wbmpv_pkg::DIM_W:3];
  assign prod_full = row_bytes * s1_r.height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_r      <= s1_r;
      s2_prod_r <= prod_full[wbmpv_pkg::EXP_W-1:0];
    end
  end

  // Stage 3: add the header length, compare against the file size and pick the status.
  assign exp_sum = s2_prod_r + {{(wbmpv_pkg::EXP_W-wbmpv_pkg::HLEN_W){1'b0}}, s2_r.hlen};

  always_comb begin
    exp_nxt = exp_sum;
    if (s2_r.trunc) begin
      status_nxt = wbmpv_pkg::ST_TRUNC;
      exp_nxt    = '0;
    end else if (s2_r.type_nz) begin
      status_nxt = wbmpv_pkg::ST_BAD_TYPE;
    end else if (s2_r.fixed_nz) begin
      status_nxt = wbmpv_pkg::ST_BAD_FIXED;
    end else if ({{(wbmpv_pkg::FSIZE_W-wbmpv_pkg::EXP_W){1'b0}}, exp_sum} != fsize_r) begin
      status_nxt = wbmpv_pkg::ST_SIZE_MISM;
    end else begin
      status_nxt = wbmpv_pkg::ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_status_r <= status_nxt;
      out_width_r  <= s2_r.width;
      out_height_r <= s2_r.height;
      out_hlen_r   <= s2_r.hlen;
      out_exp_r    <= exp_nxt;
    end
  end

  // Result transfer.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_exp_r, out_hlen_r, out_height_r, out_width_r};

endmodule

>>> rtl/core/wbmpv_parser.sv
module wbmpv_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic [wbmpv_pkg::BYTE_W-1:0]       data_byte,
  input  logic                               first_byte,
  input  logic                               end_of_data,
  output logic                               emit,
  output wbmpv_pkg::hdr_t                    hdr
);

  wbmpv_pkg::phase_t                  phase_r, phase_nxt, cur_phase;
  logic [wbmpv_pkg::DIM_W-1:0]        acc_r, acc_nxt, cur_acc, acc_shift;
  logic [wbmpv_pkg::FCNT_W-1:0]       fcnt_r, fcnt_nxt, cur_fcnt, fcnt_inc;
  logic [wbmpv_pkg::HLEN_W-1:0]       hcnt_r, hcnt_nxt, cur_hcnt, hcnt_inc;
  logic                               type_nz_r, type_nz_nxt, cur_type_nz;
  logic                               fixed_nz_r, fixed_nz_nxt, cur_fixed_nz;
  logic [wbmpv_pkg::DIM_W-1:0]        width_r, width_nxt, cur_width;
  logic                               last_grp;

  // A first byte restarts the parser before the byte itself is handled.
  always_comb begin
    if (first_byte) begin
      cur_phase    = wbmpv_pkg::PH_TYPE;
      cur_acc      = '0;
      cur_fcnt     = '0;
      cur_hcnt     = '0;
      cur_type_nz  = 1'b0;
      cur_fixed_nz = 1'b0;
      cur_width    = '0;
    end else begin
      cur_phase    = phase_r;
      cur_acc      = acc_r;
      cur_fcnt     = fcnt_r;
      cur_hcnt     = hcnt_r;
      cur_type_nz  = type_nz_r;
      cur_fixed_nz = fixed_nz_r;
      cur_width    = width_r;
    end
  end

  // Shift in the next 7-bit group and detect the end of the integer.
  assign acc_shift = {cur_acc[wbmpv_pkg::DIM_W-8:0], data_byte[6:0]};
  assign fcnt_inc  = cur_fcnt + 3'd1;
  assign hcnt_inc  = cur_hcnt + 5'd1;
  assign last_grp  = !data_byte[7] || (fcnt_inc >= wbmpv_pkg::MBI_MAX_BYTES);

  // Phase sequencing and result generation.
  always_comb begin
    phase_nxt    = cur_phase;
    acc_nxt      = cur_acc;
    fcnt_nxt     = cur_fcnt;
    hcnt_nxt     = cur_hcnt;
    type_nz_nxt  = cur_type_nz;
    fixed_nz_nxt = cur_fixed_nz;
    width_nxt    = cur_width;
    emit         = 1'b0;
    hdr.trunc    = 1'b0;
    hdr.type_nz  = cur_type_nz;
    hdr.fixed_nz = cur_fixed_nz;
    hdr.width    = cur_width;
    hdr.height   = acc_shift;
    hdr.hlen     = hcnt_inc;
    case (cur_phase)
      wbmpv_pkg::PH_TYPE, wbmpv_pkg::PH_FIXED,
      wbmpv_pkg::PH_WIDTH, wbmpv_pkg::PH_HEIGHT: begin
        if (end_of_data) begin
          // The file ended inside the header.
          emit       = 1'b1;
          hdr.trunc  = 1'b1;
          hdr.width  = (cur_phase == wbmpv_pkg::PH_HEIGHT) ? cur_width : '0;
          hdr.height = '0;
          hdr.hlen   = cur_hcnt;
          phase_nxt  = wbmpv_pkg::PH_DONE;
        end else if (cur_phase == wbmpv_pkg::PH_FIXED) begin
          hcnt_nxt     = hcnt_inc;
          fixed_nz_nxt = (data_byte != '0);
          phase_nxt    = wbmpv_pkg::PH_WIDTH;
        end else begin
          hcnt_nxt = hcnt_inc;
          if (!last_grp) begin
            acc_nxt  = acc_shift;
            fcnt_nxt = fcnt_inc;
          end else begin
            acc_nxt  = '0;
            fcnt_nxt = '0;
            case (cur_phase)
              wbmpv_pkg::PH_TYPE: begin
                type_nz_nxt = (acc_shift != '0);
                phase_nxt   = wbmpv_pkg::PH_FIXED;
              end
              wbmpv_pkg::PH_WIDTH: begin
                width_nxt = acc_shift;
                phase_nxt = wbmpv_pkg::PH_HEIGHT;
              end
              default: begin
                // Height complete: the header is done.
                emit      = 1'b1;
                phase_nxt = wbmpv_pkg::PH_DONE;
              end
            endcase
          end
        end
      end
      default: begin
        // Done phase and unused codes ignore everything until a first byte.
        emit = 1'b0;
      end
    endcase
  end

  // State advances only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wbmpv_pkg::PH_TYPE;
      acc_r      <= '0;
      fcnt_r     <= '0;
      hcnt_r     <= '0;
      type_nz_r  <= 1'b0;
      fixed_nz_r <= 1'b0;
      width_r    <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      fcnt_r     <= fcnt_nxt;
      hcnt_r     <= hcnt_nxt;
      type_nz_r  <= type_nz_nxt;
      fixed_nz_r <= fixed_nz_nxt;
      width_r    <= width_nxt;
    end
  end

endmodule

>>> rtl/core/wbmpv_checker.sv
module wbmpv_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [135:0]                        out_tdata,
  input  logic [2:0]                          out_tuser,
  input  logic                                cfg_pready
);

  // A stalled result transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == wbmpv_pkg::ST_VALID) || (out_tuser == wbmpv_pkg::ST_BAD_TYPE)
      || (out_tuser == wbmpv_pkg::ST_BAD_FIXED) || (out_tuser == wbmpv_pkg::ST_SIZE_MISM)
      || (out_tuser == wbmpv_pkg::ST_TRUNC))
    else $error("status code out of range");

  // A truncated header reports no height and no expected size.
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wbmpv_pkg::ST_TRUNC) |->
      (out_tdata[63:32] == 32'd0) && (out_tdata[129:69] == 61'd0))
    else $error("truncated result carries size data");

  // With zero height a complete header implies the header length alone.
  a_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != wbmpv_pkg::ST_TRUNC) && (out_tdata[63:32] == 32'd0) |->
      (out_tdata[129:69] == {56'd0, out_tdata[68:64]}))
    else $error("expected size wrong for zero height");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind wbmp_header_validator wbmpv_checker u_wbmpv_checker (.*);
